[src/qbs_pkg.sv]
// shared constants of the quadratic bezier sampler
package qbs_pkg;

	localparam int SAMPLE_NUM_W = 6;
	localparam int QUEUE_DEPTH = 2;

endpackage

[src/qbs_fifo.sv]
// small register queue between the front and the back of the sampler
module qbs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

endmodule

[src/qbs_front.sv]
// front end: takes control points and forms the forward difference seeds per axis
module qbs_front #(
	parameter int SAMPLES    = 50,
	parameter int COORD_BITS = 12,
	parameter int ENTRY_W    = 6
) (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] ctrl_x,
	input  logic [COORD_BITS-1:0] ctrl_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic                  queue_full,
	output logic                  push,
	output logic [ENTRY_W-1:0]    entry
);

	localparam int N     = SAMPLES - 1;
	localparam int DEN   = N * N;
	localparam int DEN_W = $clog2(DEN + 1);
	localparam int NUM_W = COORD_BITS + DEN_W;
	localparam int ACC_W = NUM_W + 1;

	localparam logic signed [ACC_W-1:0] K_DEN = ACC_W'(DEN);
	localparam logic signed [ACC_W-1:0] K_P0  = ACC_W'(2 * N - 1);
	localparam logic signed [ACC_W-1:0] K_P1  = ACC_W'(2 * (N - 1));

	// seeds: sample 0 numerator, first difference, constant second difference
	function automatic logic [3*ACC_W-1:0] axis_init(
		input logic [COORD_BITS-1:0] p0,
		input logic [COORD_BITS-1:0] p1,
		input logic [COORD_BITS-1:0] p2
	);
		logic signed [ACC_W-1:0] s0;
		logic signed [ACC_W-1:0] s1;
		logic signed [ACC_W-1:0] s2;
		logic signed [ACC_W-1:0] num0;
		logic signed [ACC_W-1:0] d1;
		logic signed [ACC_W-1:0] d2;
		s0   = $signed(ACC_W'(p0));
		s1   = $signed(ACC_W'(p1));
		s2   = $signed(ACC_W'(p2));
		num0 = s0 * K_DEN;
		d1   = s2 + s1 * K_P1 - s0 * K_P0;
		d2   = ((s0 + s2) <<< 1) - (s1 <<< 2);
		return {num0, d1, d2};
	endfunction

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;
	assign entry    = ENTRY_W'({axis_init(start_x, ctrl_x, end_x),
	                            axis_init(start_y, ctrl_y, end_y)});

endmodule

[src/qbs_div.sv]
// pipelined exact divide by n squared with round half to even, one coordinate
module qbs_div #(
	parameter int SAMPLES    = 50,
	parameter int COORD_BITS = 12
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [COORD_BITS+$clog2((SAMPLES-1)*(SAMPLES-1)+1)-1:0] num,
	output logic [COORD_BITS-1:0]                      point
);

	localparam int N     = SAMPLES - 1;
	localparam int DEN   = N * N;
	localparam int DEN_W = $clog2(DEN + 1);
	localparam int NUM_W = COORD_BITS + DEN_W;
	localparam int SHIFT = NUM_W + DEN_W;
	localparam int M_W   = NUM_W + 2;
	localparam int P_W   = NUM_W + M_W;
	localparam int Q_W   = COORD_BITS + 1;
	localparam int R_W   = NUM_W + 2;
	localparam int RS_W  = DEN_W + 2;
	localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam logic [M_W-1:0]  K_RECIP = M_W'(RECIP);
	localparam logic [R_W-1:0]  K_DEN_W = R_W'(DEN);
	localparam logic [RS_W-1:0] K_DEN_R = RS_W'(DEN);

	logic [P_W-1:0]        prod;
	logic [Q_W-1:0]        qest_s1;
	logic [NUM_W-1:0]      num_s1;
	logic [R_W-1:0]        rem_full;
	logic [Q_W-1:0]        qest_s2;
	logic [RS_W-1:0]       rem_s2;
	logic                  neg;
	logic [Q_W-1:0]        q_corr;
	logic [RS_W-1:0]       r_corr;
	logic [RS_W-1:0]       twice_r;
	logic                  round_up;
	logic [COORD_BITS-1:0] point_q;

	// quotient estimate is exact or one too high
	assign prod = P_W'(num) * P_W'(K_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			qest_s1 <= prod[SHIFT +: Q_W];
			num_s1  <= num;
		end
	end

	assign rem_full = R_W'(num_s1) - R_W'(qest_s1) * K_DEN_W;

	always_ff @(posedge clk) begin
		if (en) begin
			qest_s2 <= qest_s1;
			rem_s2  <= rem_full[RS_W-1:0];
		end
	end

	assign neg      = rem_s2[RS_W-1];
	assign q_corr   = neg ? qest_s2 - 1'b1 : qest_s2;
	assign r_corr   = neg ? rem_s2 + K_DEN_R : rem_s2;
	assign twice_r  = r_corr << 1;
	assign round_up = (twice_r > K_DEN_R) || ((twice_r == K_DEN_R) && q_corr[0]);

	always_ff @(posedge clk) begin
		if (en) begin
			point_q <= COORD_BITS'(q_corr + Q_W'(round_up));
		end
	end

	assign point = point_q;

endmodule

[src/qbs_back.sv]
// back end: steps the curve by forward differences and streams rounded samples
module qbs_back
	import qbs_pkg::*;
#(
	parameter int SAMPLES    = 50,
	parameter int COORD_BITS = 12,
	parameter int ENTRY_W    = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    entry_valid,
	input  logic [ENTRY_W-1:0]      entry,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COORD_BITS-1:0]   point_x,
	output logic [COORD_BITS-1:0]   point_y,
	output logic [SAMPLE_NUM_W-1:0] sample_number,
	output logic                    last_sample
);

	localparam int N     = SAMPLES - 1;
	localparam int DEN   = N * N;
	localparam int DEN_W = $clog2(DEN + 1);
	localparam int NUM_W = COORD_BITS + DEN_W;
	localparam int ACC_W = NUM_W + 1;
	localparam int K_W   = $clog2(SAMPLES);
	localparam logic [K_W-1:0] K_LAST = K_W'(N);

	logic [ACC_W-1:0] e_num_x, e_d1_x, e_d2_x;
	logic [ACC_W-1:0] e_num_y, e_d1_y, e_d2_y;
	logic [ACC_W-1:0] num_x_q, d1_x_q, d2_x_q;
	logic [ACC_W-1:0] num_y_q, d1_y_q, d2_y_q;
	logic             active_q;
	logic [K_W-1:0]   k_q;
	logic             en;
	logic             run_done;
	logic             load;
	logic             valid_s1, valid_s2, out_valid_q;
	logic             last_s1, last_s2, last_q;
	logic [K_W-1:0]   idx_s1, idx_s2, sample_q;

	assign {e_num_x, e_d1_x, e_d2_x, e_num_y, e_d1_y, e_d2_y} = entry[6*ACC_W-1:0];

	assign en       = !out_valid_q || out_ready;
	assign run_done = active_q && (k_q == K_LAST);
	assign load     = en && entry_valid && (!active_q || run_done);
	assign pop      = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
		end else if (en) begin
			if (load) begin
				active_q <= 1'b1;
				k_q      <= '0;
			end else if (run_done) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_x_q <= e_num_x;
			d1_x_q  <= e_d1_x;
			d2_x_q  <= e_d2_x;
			num_y_q <= e_num_y;
			d1_y_q  <= e_d1_y;
			d2_y_q  <= e_d2_y;
		end else if (en && active_q) begin
			num_x_q <= num_x_q + d1_x_q;
			d1_x_q  <= d1_x_q + d2_x_q;
			num_y_q <= num_y_q + d1_y_q;
			d1_y_q  <= d1_y_q + d2_y_q;
		end
	end

	// sample tags travel beside the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= active_q;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1   <= k_q;
			last_s1  <= run_done;
			idx_s2   <= idx_s1;
			last_s2  <= last_s1;
			sample_q <= idx_s2;
			last_q   <= last_s2;
		end
	end

	qbs_div #(
		.SAMPLES    (SAMPLES),
		.COORD_BITS (COORD_BITS)
	) u_div_x (
		.clk   (clk),
		.en    (en),
		.num   (num_x_q[NUM_W-1:0]),
		.point (point_x)
	);

	qbs_div #(
		.SAMPLES    (SAMPLES),
		.COORD_BITS (COORD_BITS)
	) u_div_y (
		.clk   (clk),
		.en    (en),
		.num   (num_y_q[NUM_W-1:0]),
		.point (point_y)
	);

	assign out_valid     = out_valid_q;
	assign sample_number = SAMPLE_NUM_W'(sample_q);
	assign last_sample   = last_q;

endmodule

[src/quadratic_bezier_sampler.sv]
// quadratic bezier sampler: top level
//
// one input beat carries three control points (start, ctrl, end), x and y each.
// for every input beat the block streams SAMPLES output beats, sample_number
// 0 to SAMPLES-1, each with the curve point rounded half to even; last_sample
// marks the final beat of a run.
// both channels use valid/ready; a beat moves when both are high.
// the first sample of a run passes the queue, the stepper registers, the divider
// stages with their tag registers before it shows on out_valid.
// throughput: one output beat per cycle while out_ready stays high; runs follow
// each other with no gap when the next entry waits in the queue, paced by the
// forward difference stepper that makes one sample per cycle unless stalled.
// a two-entry queue sits between the input side and the stepper, so in_ready
// stays high while a run streams until two further items are waiting.
// when out_valid is high and out_ready low, the stepper and the divider pipeline
// freeze and the output beat holds; the queue keeps taking input while it has room.
// reset clears the queue, the stepper and all valid flags; no beat is pending.
module quadratic_bezier_sampler
	import qbs_pkg::*;
#(
	parameter int SAMPLES    = 50,
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COORD_BITS-1:0]   start_x,
	input  logic [COORD_BITS-1:0]   start_y,
	input  logic [COORD_BITS-1:0]   ctrl_x,
	input  logic [COORD_BITS-1:0]   ctrl_y,
	input  logic [COORD_BITS-1:0]   end_x,
	input  logic [COORD_BITS-1:0]   end_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COORD_BITS-1:0]   point_x,
	output logic [COORD_BITS-1:0]   point_y,
	output logic [SAMPLE_NUM_W-1:0] sample_number,
	output logic                    last_sample
);

	localparam int N       = SAMPLES - 1;
	localparam int DEN_W   = $clog2(N * N + 1);
	localparam int ACC_W   = COORD_BITS + DEN_W + 1;
	localparam int ENTRY_W = 6 * ACC_W;

	logic               queue_full;
	logic               queue_empty;
	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] wr_entry;
	logic [ENTRY_W-1:0] rd_entry;

	qbs_front #(
		.SAMPLES    (SAMPLES),
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_x    (start_x),
		.start_y    (start_y),
		.ctrl_x     (ctrl_x),
		.ctrl_y     (ctrl_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.queue_full (queue_full),
		.push       (push),
		.entry      (wr_entry)
	);

	qbs_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_entry),
		.full   (queue_full),
		.pop    (pop),
		.rdata  (rd_entry),
		.empty  (queue_empty)
	);

	qbs_back #(
		.SAMPLES    (SAMPLES),
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.entry_valid   (!queue_empty),
		.entry         (rd_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.sample_number (sample_number),
		.last_sample   (last_sample)
	);

endmodule

[src/qbs_checker.sv]
// port-level checks of the quadratic bezier sampler and their binding
module qbs_checker
	import qbs_pkg::*;
#(
	parameter int SAMPLES    = 50,
	parameter int COORD_BITS = 12
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [COORD_BITS-1:0]   point_x,
	input logic [COORD_BITS-1:0]   point_y,
	input logic [SAMPLE_NUM_W-1:0] sample_number,
	input logic                    last_sample
);

	localparam logic [SAMPLE_NUM_W-1:0] LAST_NUM = SAMPLE_NUM_W'(SAMPLES - 1);

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output beat pending during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(sample_number) && $stable(last_sample))
		else $error("stalled output beat changed");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_sample == (sample_number == LAST_NUM)))
		else $error("last mark does not match sample index");

	a_run_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_sample |=>
			out_valid && (sample_number == SAMPLE_NUM_W'($past(sample_number) + 1'b1)))
		else $error("run broken or sample index skipped");

	a_run_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_sample |=> !out_valid || (sample_number == '0))
		else $error("new run does not start at sample zero");

endmodule

bind quadratic_bezier_sampler qbs_checker #(
	.SAMPLES    (SAMPLES),
	.COORD_BITS (COORD_BITS)
) u_qbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.point_x       (point_x),
	.point_y       (point_y),
	.sample_number (sample_number),
	.last_sample   (last_sample)
);
